// ===== hw/rtl/sart_pkg.sv =====
// Shared types and constants of the sorted address range table.
// Used by sart_ctrl, sart_dp and sorted_address_range_table_top; no dependencies.
`default_nettype none
package sart_pkg;

   localparam int unsigned REQ_W      = 3;
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned IDX_W      = 6;
   localparam int unsigned USED_OUT_W = 7;
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 80;
   localparam int unsigned OP_W       = 5;

   localparam logic [REQ_W-1:0] REQ_ADD      = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_CONTAINS = 3'd2;
   localparam logic [REQ_W-1:0] REQ_IDENT    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd5;

   localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
   localparam logic [OP_W-1:0] OP_BS_RD    = 5'd2;
   localparam logic [OP_W-1:0] OP_BS_STEP  = 5'd3;
   localparam logic [OP_W-1:0] OP_ADD_SET  = 5'd4;
   localparam logic [OP_W-1:0] OP_DEL_INIT = 5'd5;
   localparam logic [OP_W-1:0] OP_INS_INIT = 5'd6;
   localparam logic [OP_W-1:0] OP_SH_RD    = 5'd7;
   localparam logic [OP_W-1:0] OP_SH_WR    = 5'd8;
   localparam logic [OP_W-1:0] OP_INS_PUT  = 5'd9;
   localparam logic [OP_W-1:0] OP_DS_RD    = 5'd10;
   localparam logic [OP_W-1:0] OP_DS_EVAL  = 5'd11;
   localparam logic [OP_W-1:0] OP_DS_END   = 5'd12;
   localparam logic [OP_W-1:0] OP_CP_INIT  = 5'd13;
   localparam logic [OP_W-1:0] OP_CP_RD    = 5'd14;
   localparam logic [OP_W-1:0] OP_CP_WR    = 5'd15;
   localparam logic [OP_W-1:0] OP_CP_END   = 5'd16;
   localparam logic [OP_W-1:0] OP_Q_RD     = 5'd17;
   localparam logic [OP_W-1:0] OP_Q_EVAL   = 5'd18;
   localparam logic [OP_W-1:0] OP_RD_RD    = 5'd19;
   localparam logic [OP_W-1:0] OP_RD_EVAL  = 5'd20;
   localparam logic [OP_W-1:0] OP_CLEAR    = 5'd21;
   localparam logic [OP_W-1:0] OP_RSP      = 5'd22;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             bs_more;
      logic             ptr_lt_used;
      logic             sh_more;
      logic             full;
      logic             stop;
      logic             split;
      logic             any_drop;
      logic             idx_ok;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/sart_dp.sv =====
// Datapath of the sorted address range table: entry memory, pointers, compares, result word.
// Depends on sart_pkg; driven by sart_ctrl through dp_cmd_type.
`default_nettype none
module sart_dp #(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire sart_pkg::dp_cmd_type                 cmd,
   output sart_pkg::dp_status_type                   stat,
   input  wire logic [sart_pkg::REQ_W-1:0]           req_type,
   input  wire logic [sart_pkg::REQ_DATA_W-1:0]      req_data,
   output logic      [sart_pkg::RSP_DATA_W-1:0]      rsp_data
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = AW + 1;
   localparam int unsigned IW = (CW > sart_pkg::IDX_W) ? CW : sart_pkg::IDX_W;
   localparam int unsigned UW = (CW > sart_pkg::USED_OUT_W) ? CW : sart_pkg::USED_OUT_W;
   localparam int unsigned MW = 2 * sart_pkg::ADDR_W + 1;
   localparam int unsigned PADW = sart_pkg::RSP_DATA_W - 2 - 2 * sart_pkg::ADDR_W
                                  - sart_pkg::USED_OUT_W;

   logic [MW-1:0] ram_ff [CAPACITY];
   logic [MW-1:0] rd_word_ff;

   logic [sart_pkg::REQ_W-1:0]  type_ff, type_in;
   logic [sart_pkg::ADDR_W-1:0] b_ff, b_in, e_ff, e_in;
   logic [sart_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [CW-1:0] used_ff, used_in, lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in;
   logic [CW-1:0] wr_ff, wr_in, start_ff, start_in, send_ff, send_in;
   logic [CW-1:0] ins_pos_ff, ins_pos_in;
   logic [sart_pkg::ADDR_W-1:0] ins_b_ff, ins_b_in, ins_e_ff, ins_e_in;
   logic hit_ff, hit_in, ovf_ff, ovf_in, drop_ff, drop_in;
   logic [sart_pkg::ADDR_W-1:0] ob_ff, ob_in, ol_ff, ol_in;
   logic [sart_pkg::RSP_DATA_W-1:0] rsp_ff, rsp_in;

   logic          mem_we, mem_re;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [MW-1:0] wr_word;

   logic [sart_pkg::ADDR_W-1:0] rb, rend;
   logic                        rm;
   logic [CW:0]                 mid_sum;
   logic [CW-1:0]               mid, ptr_dec, ptr_inc;
   logic [IW-1:0]               idx_ext, used_iw;
   logic [UW-1:0]               used_uw;
   logic                        ev_stop, ev_split, ev_cover;

   assign rb      = rd_word_ff[sart_pkg::ADDR_W-1:0];
   assign rend    = rd_word_ff[2*sart_pkg::ADDR_W-1:sart_pkg::ADDR_W];
   assign rm      = rd_word_ff[MW-1];
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];
   assign ptr_dec = ptr_ff - 1'b1;
   assign ptr_inc = ptr_ff + 1'b1;
   assign idx_ext = IW'(idx_ff);
   assign used_iw = IW'(used_ff);
   assign used_uw = UW'(used_ff);

   assign ev_stop  = (rb >= e_ff);
   assign ev_cover = (rb >= b_ff) && (rend <= e_ff);
   assign ev_split = !ev_stop && !ev_cover && (rb < b_ff) && (rend > e_ff);

   assign stat.req_type    = type_ff;
   assign stat.bs_more     = (lo_ff < hi_ff);
   assign stat.ptr_lt_used = (ptr_ff < used_ff);
   assign stat.sh_more     = (ptr_ff > ins_pos_ff);
   assign stat.full        = (used_ff >= CW'(CAPACITY));
   assign stat.stop        = ev_stop;
   assign stat.split       = ev_split;
   assign stat.any_drop    = drop_ff;
   assign stat.idx_ok      = (idx_ext < used_iw);
   assign rsp_data         = rsp_ff;

   always_comb begin
      type_in    = type_ff;
      b_in       = b_ff;
      e_in       = e_ff;
      idx_in     = idx_ff;
      used_in    = used_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      ptr_in     = ptr_ff;
      wr_in      = wr_ff;
      start_in   = start_ff;
      send_in    = send_ff;
      ins_pos_in = ins_pos_ff;
      ins_b_in   = ins_b_ff;
      ins_e_in   = ins_e_ff;
      hit_in     = hit_ff;
      ovf_in     = ovf_ff;
      drop_in    = drop_ff;
      ob_in      = ob_ff;
      ol_in      = ol_ff;
      rsp_in     = rsp_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      rd_addr    = '0;
      wr_addr    = '0;
      wr_word    = '0;
      unique case (cmd.op)
         sart_pkg::OP_NONE: begin
         end
         sart_pkg::OP_LOAD: begin
            type_in = req_type;
            b_in    = req_data[31:0];
            e_in    = req_data[31:0] + req_data[63:32];
            idx_in  = req_data[69:64];
            lo_in   = '0;
            hi_in   = used_ff;
            ptr_in  = '0;
            hit_in  = 1'b0;
            ovf_in  = 1'b0;
            drop_in = 1'b0;
            ob_in   = '0;
            ol_in   = '0;
         end
         sart_pkg::OP_BS_RD: begin
            ptr_in  = mid;
            mem_re  = 1'b1;
            rd_addr = mid[AW-1:0];
         end
         sart_pkg::OP_BS_STEP: begin
            if (rb < b_ff) begin
               lo_in = ptr_inc;
            end else begin
               hi_in = ptr_ff;
            end
         end
         sart_pkg::OP_ADD_SET: begin
            ins_pos_in = lo_ff;
            ins_b_in   = b_ff;
            ins_e_in   = e_ff;
         end
         sart_pkg::OP_DEL_INIT: begin
            start_in = (lo_ff != '0) ? (lo_ff - 1'b1) : '0;
            ptr_in   = (lo_ff != '0) ? (lo_ff - 1'b1) : '0;
         end
         sart_pkg::OP_INS_INIT: begin
            if (used_ff >= CW'(CAPACITY)) begin
               ovf_in = 1'b1;
            end else begin
               ptr_in = used_ff;
            end
         end
         sart_pkg::OP_SH_RD: begin
            mem_re  = 1'b1;
            rd_addr = ptr_dec[AW-1:0];
         end
         sart_pkg::OP_SH_WR: begin
            mem_we  = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_word = rd_word_ff;
            ptr_in  = ptr_dec;
         end
         sart_pkg::OP_INS_PUT: begin
            mem_we  = 1'b1;
            wr_addr = ins_pos_ff[AW-1:0];
            wr_word = {1'b0, ins_e_ff, ins_b_ff};
            used_in = used_ff + 1'b1;
         end
         sart_pkg::OP_DS_RD: begin
            mem_re  = 1'b1;
            rd_addr = ptr_ff[AW-1:0];
         end
         sart_pkg::OP_DS_EVAL: begin
            wr_addr = ptr_ff[AW-1:0];
            if (ev_stop) begin
               send_in = ptr_ff;
            end else if (ev_cover) begin
               mem_we  = 1'b1;
               wr_word = {1'b1, rend, rb};
               hit_in  = 1'b1;
               drop_in = 1'b1;
               ptr_in  = ptr_inc;
            end else if (rb < b_ff) begin
               mem_we = 1'b1;
               if (rend > e_ff) begin
                  wr_word    = {1'b0, b_ff, rb};
                  hit_in     = 1'b1;
                  ins_pos_in = ptr_inc;
                  ins_b_in   = e_ff;
                  ins_e_in   = rend;
                  send_in    = ptr_inc;
               end else if (rend > b_ff) begin
                  wr_word = {1'b0, b_ff, rb};
                  hit_in  = 1'b1;
                  ptr_in  = ptr_inc;
               end else begin
                  wr_word = {1'b0, rend, rb};
                  ptr_in  = ptr_inc;
               end
            end else begin
               mem_we  = 1'b1;
               wr_word = {1'b0, rend, e_ff};
               hit_in  = 1'b1;
               ptr_in  = ptr_inc;
            end
         end
         sart_pkg::OP_DS_END: begin
            send_in = ptr_ff;
         end
         sart_pkg::OP_CP_INIT: begin
            ptr_in = start_ff;
            wr_in  = start_ff;
         end
         sart_pkg::OP_CP_RD: begin
            mem_re  = 1'b1;
            rd_addr = ptr_ff[AW-1:0];
         end
         sart_pkg::OP_CP_WR: begin
            if (!((ptr_ff < send_ff) && rm)) begin
               mem_we  = 1'b1;
               wr_addr = wr_ff[AW-1:0];
               wr_word = {1'b0, rend, rb};
               wr_in   = wr_ff + 1'b1;
            end
            ptr_in = ptr_inc;
         end
         sart_pkg::OP_CP_END: begin
            used_in = wr_ff;
         end
         sart_pkg::OP_Q_RD: begin
            mem_re  = 1'b1;
            rd_addr = ptr_ff[AW-1:0];
         end
         sart_pkg::OP_Q_EVAL: begin
            if (type_ff == sart_pkg::REQ_CONTAINS) begin
               if ((rb <= b_ff) && (rend >= e_ff)) begin
                  hit_in = 1'b1;
               end
            end else if ((rb == b_ff) && (rend == e_ff)) begin
               hit_in = 1'b1;
            end
            ptr_in = ptr_inc;
         end
         sart_pkg::OP_RD_RD: begin
            mem_re  = 1'b1;
            rd_addr = idx_ext[AW-1:0];
         end
         sart_pkg::OP_RD_EVAL: begin
            hit_in = 1'b1;
            ob_in  = rb;
            ol_in  = rend - rb;
         end
         sart_pkg::OP_CLEAR: begin
            used_in = '0;
         end
         sart_pkg::OP_RSP: begin
            rsp_in = {{PADW{1'b0}}, used_uw[sart_pkg::USED_OUT_W-1:0], ol_ff, ob_ff,
                      ovf_ff, hit_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ram_ff[wr_addr] <= wr_word;
      end
      if (mem_re) begin
         rd_word_ff <= ram_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      b_ff       <= b_in;
      e_ff       <= e_in;
      idx_ff     <= idx_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      ptr_ff     <= ptr_in;
      wr_ff      <= wr_in;
      start_ff   <= start_in;
      send_ff    <= send_in;
      ins_pos_ff <= ins_pos_in;
      ins_b_ff   <= ins_b_in;
      ins_e_ff   <= ins_e_in;
      hit_ff     <= hit_in;
      ovf_ff     <= ovf_in;
      drop_ff    <= drop_in;
      ob_ff      <= ob_in;
      ol_ff      <= ol_in;
      rsp_ff     <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sart_ctrl.sv =====
// Controller of the sorted address range table: request sequencing and stream handshakes.
// Depends on sart_pkg; commands sart_dp.
`default_nettype none
module sart_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output sart_pkg::dp_cmd_type         cmd,
   input  wire sart_pkg::dp_status_type stat
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_DISP = 5'd1;
   localparam logic [4:0] S_BS   = 5'd2;
   localparam logic [4:0] S_BSW  = 5'd3;
   localparam logic [4:0] S_ADD  = 5'd4;
   localparam logic [4:0] S_INS  = 5'd5;
   localparam logic [4:0] S_SH   = 5'd6;
   localparam logic [4:0] S_SHW  = 5'd7;
   localparam logic [4:0] S_DELI = 5'd8;
   localparam logic [4:0] S_DS   = 5'd9;
   localparam logic [4:0] S_DSW  = 5'd10;
   localparam logic [4:0] S_CPI  = 5'd11;
   localparam logic [4:0] S_CP   = 5'd12;
   localparam logic [4:0] S_CPW  = 5'd13;
   localparam logic [4:0] S_QS   = 5'd14;
   localparam logic [4:0] S_QW   = 5'd15;
   localparam logic [4:0] S_RD   = 5'd16;
   localparam logic [4:0] S_RDW  = 5'd17;
   localparam logic [4:0] S_CLR  = 5'd18;
   localparam logic [4:0] S_DONE = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       is_add;

   assign is_add     = (stat.req_type == sart_pkg::REQ_ADD);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = sart_pkg::OP_NONE;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = sart_pkg::OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (stat.req_type) inside
               sart_pkg::REQ_ADD, sart_pkg::REQ_DELETE: state_in = S_BS;
               sart_pkg::REQ_CONTAINS, sart_pkg::REQ_IDENT: state_in = S_QS;
               sart_pkg::REQ_READ: state_in = S_RD;
               sart_pkg::REQ_CLEAR: state_in = S_CLR;
               default: state_in = S_DONE;
            endcase
         end
         S_BS: begin
            if (stat.bs_more) begin
               cmd.op   = sart_pkg::OP_BS_RD;
               state_in = S_BSW;
            end else begin
               state_in = is_add ? S_ADD : S_DELI;
            end
         end
         S_BSW: begin
            cmd.op   = sart_pkg::OP_BS_STEP;
            state_in = S_BS;
         end
         S_ADD: begin
            cmd.op   = sart_pkg::OP_ADD_SET;
            state_in = S_INS;
         end
         S_INS: begin
            cmd.op = sart_pkg::OP_INS_INIT;
            if (stat.full) begin
               state_in = is_add ? S_DONE : S_CPI;
            end else begin
               state_in = S_SH;
            end
         end
         S_SH: begin
            if (stat.sh_more) begin
               cmd.op   = sart_pkg::OP_SH_RD;
               state_in = S_SHW;
            end else begin
               cmd.op   = sart_pkg::OP_INS_PUT;
               state_in = is_add ? S_DONE : S_CPI;
            end
         end
         S_SHW: begin
            cmd.op   = sart_pkg::OP_SH_WR;
            state_in = S_SH;
         end
         S_DELI: begin
            cmd.op   = sart_pkg::OP_DEL_INIT;
            state_in = S_DS;
         end
         S_DS: begin
            if (stat.ptr_lt_used) begin
               cmd.op   = sart_pkg::OP_DS_RD;
               state_in = S_DSW;
            end else begin
               cmd.op   = sart_pkg::OP_DS_END;
               state_in = S_CPI;
            end
         end
         S_DSW: begin
            cmd.op = sart_pkg::OP_DS_EVAL;
            if (stat.stop) begin
               state_in = S_CPI;
            end else if (stat.split) begin
               state_in = S_INS;
            end else begin
               state_in = S_DS;
            end
         end
         S_CPI: begin
            if (stat.any_drop) begin
               cmd.op   = sart_pkg::OP_CP_INIT;
               state_in = S_CP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CP: begin
            if (stat.ptr_lt_used) begin
               cmd.op   = sart_pkg::OP_CP_RD;
               state_in = S_CPW;
            end else begin
               cmd.op   = sart_pkg::OP_CP_END;
               state_in = S_DONE;
            end
         end
         S_CPW: begin
            cmd.op   = sart_pkg::OP_CP_WR;
            state_in = S_CP;
         end
         S_QS: begin
            if (stat.ptr_lt_used) begin
               cmd.op   = sart_pkg::OP_Q_RD;
               state_in = S_QW;
            end else begin
               state_in = S_DONE;
            end
         end
         S_QW: begin
            cmd.op   = sart_pkg::OP_Q_EVAL;
            state_in = S_QS;
         end
         S_RD: begin
            if (stat.idx_ok) begin
               cmd.op   = sart_pkg::OP_RD_RD;
               state_in = S_RDW;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RDW: begin
            cmd.op   = sart_pkg::OP_RD_EVAL;
            state_in = S_DONE;
         end
         S_CLR: begin
            cmd.op   = sart_pkg::OP_CLEAR;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = sart_pkg::OP_RSP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_address_range_table_top.sv =====
// Sorted address range table: keeps up to CAPACITY (begin, end) ranges ordered by begin
// address and serves add, delete, contains, identical, read and clear requests, one response
// word per request word. One request is worked at a time; the next request word is taken
// while the previous response still waits in its output register. All table work goes through
// a single-port entry memory, each entry touched being read in one state and evaluated or
// written in the next: a binary search over the used entries, an add or split insert that
// shifts the entries from used down to the position, contains and identical scans of all
// used entries, and for a delete its scan and, when entries are removed, a compaction pass
// from start to used.
// Depends on sart_pkg, sart_ctrl and sart_dp.
`default_nettype none
module sorted_address_range_table_top #(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata: start_addr[31:0], span_len[63:32], entry_index[69:64], zero [71:70]
   input  wire logic [sart_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: req_type[2:0]
   input  wire logic [sart_pkg::REQ_W-1:0]           req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata: hit[0], overflow[1], entry_begin[33:2], entry_len[65:34],
   //        used_count[72:66], zero [79:73]
   output logic      [sart_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   sart_pkg::dp_cmd_type    cmd;
   sart_pkg::dp_status_type stat;

   sart_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   sart_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_type (req_tuser),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule
`default_nettype wire
